@@ hw/rtl/binary_object_stream_validator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the object stream validator
// Shared helpers for concurrent checks, written once and used by the top level.
// ----------------------------------------------------------------------------
`ifndef BINARY_OBJECT_STREAM_VALIDATOR_CORE_DEFINES_SVH
`define BINARY_OBJECT_STREAM_VALIDATOR_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BOSV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define BOSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bosv_pkg.sv @@
// ----------------------------------------------------------------------------
// Object stream validator package
// Types, codes and tables shared by the front, the queue and the parser.
// ----------------------------------------------------------------------------
package bosv_pkg;

  localparam int MaxDepth = 16;
  localparam int LvlW     = $clog2(MaxDepth + 1);
  localparam int IdxW     = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_SMALL   = 3'd1;
  localparam logic [2:0] ERR_SHORT   = 3'd2;
  localparam logic [2:0] ERR_OVERRUN = 3'd3;
  localparam logic [2:0] ERR_TYPE    = 3'd4;
  localparam logic [2:0] ERR_DEEP    = 3'd5;

  typedef enum logic [1:0] {
    PU_VALUE = 2'd0,
    PU_KEY   = 2'd1,
    PU_ARRAY = 2'd2,
    PU_OBJ   = 2'd3
  } purpose_t;

  // Beat passed from the front to the parser.
  typedef struct packed {
    logic       parse;    // byte lies inside the declared value region
    logic [7:0] data;
    logic       last;
    logic [2:0] pre_err;  // size or length verdict known at the front
  } qbeat_t;

  function automatic logic [3:0] fixed_len(input logic [3:0] code);
    logic [3:0] len;
    unique case (code)
      4'd1, 4'd2, 4'd6:         len = 4'd1;
      4'd3, 4'd7:               len = 4'd2;
      4'd4, 4'd8, 4'd10:        len = 4'd4;
      4'd5, 4'd9, 4'd11:        len = 4'd8;
      default:                  len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/bosv_front.sv @@
// ----------------------------------------------------------------------------
// Object stream validator front
// Reads the size header, counts bytes and tags each beat for the parser.
// ----------------------------------------------------------------------------
module bosv_front import bosv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  output logic       q_valid,
  input  logic       q_ready,
  output qbeat_t     q_beat
);

  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic        hdr_done_r, hdr_done_nxt;
  logic [31:0] decl_r, decl_nxt;
  logic [32:0] cons_r, cons_nxt;
  logic [32:0] cons_inc;
  logic        acc;

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;
  assign acc       = in_tvalid && in_tready;
  assign cons_inc  = (cons_r == '1) ? cons_r : cons_r + 33'd1;

  always_comb begin
    hdr_cnt_nxt  = hdr_cnt_r;
    hdr_done_nxt = hdr_done_r;
    decl_nxt     = decl_r;
    if (!hdr_done_r) begin
      unique case (hdr_cnt_r)
        2'd0: decl_nxt[7:0]   = in_tdata;
        2'd1: decl_nxt[15:8]  = in_tdata;
        2'd2: decl_nxt[23:16] = in_tdata;
        default: decl_nxt[31:24] = in_tdata;
      endcase
      hdr_cnt_nxt  = hdr_cnt_r + 2'd1;
      hdr_done_nxt = (hdr_cnt_r == 2'd3);
    end
    cons_nxt = cons_inc;
    q_beat.data  = in_tdata;
    q_beat.last  = in_tlast;
    q_beat.parse = hdr_done_r && (decl_r >= 32'd5) && (cons_r < {1'b0, decl_nxt});
    if ((cons_inc < 33'd5) || (decl_nxt < 32'd5)) q_beat.pre_err = ERR_SMALL;
    else if (cons_inc < {1'b0, decl_nxt})        q_beat.pre_err = ERR_SHORT;
    else                                          q_beat.pre_err = ERR_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_tlast)) begin
      hdr_cnt_r  <= '0;
      hdr_done_r <= 1'b0;
      decl_r     <= '0;
      cons_r     <= '0;
    end else if (acc) begin
      hdr_cnt_r  <= hdr_cnt_nxt;
      hdr_done_r <= hdr_done_nxt;
      decl_r     <= decl_nxt;
      cons_r     <= cons_nxt;
    end
  end

endmodule

@@ hw/rtl/bosv_queue.sv @@
// ----------------------------------------------------------------------------
// Object stream validator beat queue
// Small FIFO between the front and the parser.
// ----------------------------------------------------------------------------
module bosv_queue import bosv_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  qbeat_t wr_beat,
  output logic   rd_valid,
  input  logic   rd_ready,
  output qbeat_t rd_beat
);

  qbeat_t           mem [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;
  logic             wr, rd;

  assign wr_ready = (cnt_r != (QPtrW+1)'(QDepth));
  assign rd_valid = (cnt_r != '0);
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;
  assign rd_beat  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
    end
  end

endmodule

@@ hw/rtl/bosv_parser.sv @@
// ----------------------------------------------------------------------------
// Object stream validator parser
// Walks the typed value with a stack of open arrays and objects.
// ----------------------------------------------------------------------------
module bosv_parser import bosv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  qbeat_t     q_beat,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata
);

  typedef enum logic [2:0] {
    S_TYPE, S_SKIP, S_PREFIX, S_LEN, S_POP, S_DONE
  } state_t;

  state_t          st_r;
  logic [63:0]     skip_r, len_r;
  logic [3:0]      pleft_r;
  logic [2:0]      bidx_r;
  purpose_t        pur_r;
  logic [LvlW-1:0] lvl_r;
  logic [2:0]      verd_r;
  logic            pend_last_r;
  logic [2:0]      pend_err_r;
  logic            ovalid_r;
  logic [2:0]      oerr_r;
  logic [63:0]     cnt_mem [MaxDepth];
  logic            kind_mem [MaxDepth];  // 1 array, 0 object
  logic [63:0]     top_cnt;
  logic            top_arr;
  logic [IdxW-1:0] top_idx;
  logic [63:0]     len_full;
  logic [63:0]     len_n;
  logic            take;
  logic            emit;
  logic [2:0]      fin_err;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'd0, oerr_r, (oerr_r == ERR_OK)};
  // A pop walk blocks new beats; a stored verdict waits for the output slot.
  assign q_ready    = (st_r != S_POP) && !pend_last_r && !(ovalid_r && !out_tready);
  assign take       = q_valid && q_ready;
  assign emit       = (st_r != S_POP) && pend_last_r && (!ovalid_r || out_tready);
  assign top_idx    = IdxW'(lvl_r - LvlW'(1));
  assign top_cnt    = cnt_mem[top_idx];
  assign top_arr    = kind_mem[top_idx];

  always_comb begin
    len_full = len_r;
    unique case (bidx_r)
      3'd0: len_full[7:0]   = q_beat.data;
      3'd1: len_full[15:8]  = q_beat.data;
      3'd2: len_full[23:16] = q_beat.data;
      3'd3: len_full[31:24] = q_beat.data;
      3'd4: len_full[39:32] = q_beat.data;
      3'd5: len_full[47:40] = q_beat.data;
      3'd6: len_full[55:48] = q_beat.data;
      default: len_full[63:56] = q_beat.data;
    endcase
    len_n = (st_r == S_PREFIX) ? {56'd0, q_beat.data} : len_full;
  end

  always_comb begin
    if (pend_err_r != ERR_OK)   fin_err = pend_err_r;
    else if (verd_r != ERR_OK)  fin_err = verd_r;
    else if (st_r != S_DONE)    fin_err = ERR_OVERRUN;
    else                        fin_err = ERR_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_TYPE; skip_r <= '0; len_r <= '0; pleft_r <= '0; bidx_r <= '0;
      pur_r <= PU_VALUE; lvl_r <= '0; verd_r <= ERR_OK;
      pend_last_r <= 1'b0; pend_err_r <= ERR_OK; ovalid_r <= 1'b0; oerr_r <= ERR_OK;
    end else begin
      if (ovalid_r && out_tready && !emit) ovalid_r <= 1'b0;
      if (st_r == S_POP) begin
        // One stack level per cycle: decrement the top count or close it.
        if (lvl_r == '0) st_r <= S_DONE;
        else if (top_cnt != 64'd1) begin
          cnt_mem[top_idx] <= top_cnt - 64'd1;
          if (top_arr) st_r <= S_TYPE;
          else begin st_r <= S_PREFIX; pur_r <= PU_KEY; end
        end else lvl_r <= lvl_r - LvlW'(1);
      end else if (pend_last_r) begin
        if (emit) begin
          oerr_r <= fin_err; ovalid_r <= 1'b1; pend_last_r <= 1'b0;
          st_r <= S_TYPE; lvl_r <= '0; verd_r <= ERR_OK; pur_r <= PU_VALUE;
        end
      end else if (take) begin
        if (q_beat.parse && verd_r == ERR_OK) begin
          unique case (st_r)
            S_TYPE: begin
              if (q_beat.data == 8'd0) st_r <= S_POP;
              else if (q_beat.data < 8'd12) begin
                skip_r <= {60'd0, fixed_len(q_beat.data[3:0])};
                pur_r <= PU_VALUE; st_r <= S_SKIP;
              end else if (q_beat.data <= 8'd15) begin
                pur_r <= (q_beat.data == 8'd14) ? PU_ARRAY :
                         (q_beat.data == 8'd15) ? PU_OBJ : PU_VALUE;
                st_r <= S_PREFIX;
              end else verd_r <= ERR_TYPE;
            end
            S_SKIP: begin
              skip_r <= skip_r - 64'd1;
              if (skip_r == 64'd1) st_r <= (pur_r == PU_KEY) ? S_TYPE : S_POP;
            end
            S_PREFIX, S_LEN: begin
              if (st_r == S_PREFIX && q_beat.data >= 8'hFD) begin
                len_r <= '0; bidx_r <= '0;
                pleft_r <= (q_beat.data == 8'hFF) ? 4'd8 :
                           (q_beat.data == 8'hFE) ? 4'd4 : 4'd2;
                st_r <= S_LEN;
              end else if (st_r == S_LEN && pleft_r != 4'd1) begin
                len_r <= len_full; bidx_r <= bidx_r + 3'd1; pleft_r <= pleft_r - 4'd1;
              end else begin
                // Length complete: plain prefix byte or last length byte.
                if (pur_r == PU_VALUE || pur_r == PU_KEY) begin
                  if (len_n != 64'd0) begin skip_r <= len_n; st_r <= S_SKIP; end
                  else st_r <= (pur_r == PU_KEY) ? S_TYPE : S_POP;
                end else if (len_n == 64'd0) st_r <= S_POP;
                else if (lvl_r >= LvlW'(MaxDepth)) verd_r <= ERR_DEEP;
                else begin
                  cnt_mem[IdxW'(lvl_r)]  <= len_n;
                  kind_mem[IdxW'(lvl_r)] <= (pur_r == PU_ARRAY);
                  lvl_r <= lvl_r + LvlW'(1);
                  if (pur_r == PU_ARRAY) st_r <= S_TYPE;
                  else begin st_r <= S_PREFIX; pur_r <= PU_KEY; end
                end
              end
            end
            default: ;
          endcase
        end
        if (q_beat.last) begin
          pend_last_r <= 1'b1;
          pend_err_r  <= q_beat.pre_err;
        end
      end
    end
  end

endmodule

@@ hw/rtl/binary_object_stream_validator_core.sv @@
// ----------------------------------------------------------------------------
// Binary object stream validator
// Checks a serialized typed object byte by byte and gives one verdict per buffer.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)             | tlast
//  in_     | in  | data_byte[7:0]                 | last_byte
//  out_    | out | is_valid, error_kind[2:0], pad  | -
//
// The front tags a beat in the cycle it is accepted and writes it to the
// queue, from whose registered storage the parser takes it. A beat that
// completes a value starts a pop walk that holds the parser while it closes
// finished stack levels; any other beat does not hold it. The parser marks
// the last beat pending and registers the verdict once any pop walk has ended
// and the output slot is free. Reset is synchronous; a full four-beat queue
// stalls the input, a held result stalls the parser.
`include "binary_object_stream_validator_core_defines.svh"
module binary_object_stream_validator_core import bosv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_valid, [3:1] error_kind, [7:4] zero
);

  logic   fq_valid, fq_ready, qp_valid, qp_ready;
  qbeat_t fq_beat, qp_beat;

  bosv_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_beat(fq_beat)
  );

  bosv_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_beat(fq_beat),
    .rd_valid(qp_valid), .rd_ready(qp_ready), .rd_beat(qp_beat)
  );

  bosv_parser u_parser (
    .clk, .rst_n, .q_valid(qp_valid), .q_ready(qp_ready), .q_beat(qp_beat),
    .out_tvalid, .out_tready, .out_tdata
  );

  `BOSV_ASSERT_IMP(a_valid_flag, out_tvalid,
                   out_tdata[0] == (out_tdata[3:1] == ERR_OK), "valid flag mismatch")
  `BOSV_ASSERT_IMP(a_err_range, out_tvalid, out_tdata[3:1] <= ERR_DEEP,
                   "error code out of range")
  `BOSV_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "result dropped")
endmodule
